### sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants for the token bucket block
// Operation codes, register indexes, level width and multiplier status.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int LEVEL_W     = 32;
    localparam int BURST_W     = 16;
    localparam int AVAIL_W     = 16;
    localparam int RID_W       = 6;
    localparam int NOW_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int RID_EXT_W   = 13;

    typedef enum logic [1:0] {
        OP_ACQUIRE   = 2'd0,
        OP_QUERY     = 2'd1,
        OP_RESET_ONE = 2'd2,
        OP_RESET_ALL = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 2'd1;

    // status of the serial multiplier
    typedef struct packed {
        logic               done;
        logic               sat;
        logic [LEVEL_W-1:0] product;
    } mul_stat_t;

endpackage

### sv/ptb_mem.sv
// ----------------------------------------------------------------------------
// ptb_mem: bucket state memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptb_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ptb_mul.sv
// ----------------------------------------------------------------------------
// ptb_mul: bit-serial saturating multiplier
// elapsed * rate, one multiplier bit per cycle, MSB first; sat flags >= 2^32.
// ----------------------------------------------------------------------------
module ptb_mul
    import ptb_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] elapsed,
    input  logic [LEVEL_W-1:0]   rate,
    output mul_stat_t            stat
);

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 sat_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [TIME_BITS-1:0] mplr_reg;
    logic [LEVEL_W-1:0]   acc_reg;
    logic [LEVEL_W+1:0]   acc_next;

    // double and add: value < 2^32 doubled plus rate stays below 2^34
    always_comb begin
        acc_next = {1'b0, acc_reg, 1'b0}
                 + (mplr_reg[TIME_BITS-1] ? {2'b00, rate} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= CNT_W'(TIME_BITS);
                mplr_reg <= elapsed;
                acc_reg  <= '0;
                sat_reg  <= 1'b0;
            end else if (busy_reg) begin
                acc_reg  <= acc_next[LEVEL_W-1:0];
                sat_reg  <= sat_reg | (|acc_next[LEVEL_W+1:LEVEL_W]);
                mplr_reg <= mplr_reg << 1;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                // last multiplier bit: stop and flag the product
                busy_reg <= (cnt_reg != CNT_W'(1));
                done_reg <= (cnt_reg == CNT_W'(1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign stat.done    = done_reg;
    assign stat.sat     = sat_reg;
    assign stat.product = acc_reg;

endmodule

### sv/per_resource_token_bucket.sv
// ----------------------------------------------------------------------------
// per_resource_token_bucket: table of lazily refilled token buckets
// Acquire / query / reset per resource, 16.16 levels, serial refill multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (s_op, s_resource_id, s_now_time) arrive on a valid/ready
//   channel; each item yields exactly one result item (m_granted,
//   m_available) on the m_ channel. cfg_we/cfg_index/cfg_wdata write the
//   rate (index 0) and burst size (index 1); write them only while idle.
//   One item at a time: s_ready is high only when the sequencer is idle.
//   Resets, queries of unknown buckets and out of range ids go from the
//   read and evaluate steps straight to the final step; acquires of
//   unknown buckets and of buckets already full pass the take step first;
//   otherwise the bit-serial multiplier of elapsed ticks by the rate runs,
//   one multiplier bit per cycle, before the refill and take steps. A new
//   item is taken only once the last one has left the final step.
//   A finished result sits in the output register; the next item is taken
//   meanwhile, and its own result waits in the final step until the
//   receiver drains the register.
//   Reset clears all entry valid bits, loads rate 1.0 and burst 16, and
//   empties the output register; bucket memory needs no clearing.
// ----------------------------------------------------------------------------
module per_resource_token_bucket
    import ptb_pkg::*;
#(
    parameter int NUM_RESOURCES = 64,
    parameter int FRAC_BITS     = 16,
    parameter int TIME_BITS     = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [RID_W-1:0]      s_resource_id,
    input  logic [NOW_W-1:0]      s_now_time,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_granted,
    output logic [AVAIL_W-1:0]    m_available
);

    localparam int IDX_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int MEM_W  = TIME_BITS + LEVEL_W;
    localparam int CAP_W  = (BURST_W + FRAC_BITS > LEVEL_W + 1) ?
                            (BURST_W + FRAC_BITS) : (LEVEL_W + 1);
    localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_EVAL, ST_MUL, ST_FIN, ST_TAKE, ST_DONE
    } state_t;

    state_t               state_reg;
    logic [LEVEL_W-1:0]   rate_reg;
    logic [BURST_W-1:0]   burst_reg;
    logic [NUM_RESOURCES-1:0] valid_reg;

    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 in_range_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [LEVEL_W-1:0]   lvl_reg;
    logic [LEVEL_W-1:0]   room_reg;
    logic                 wr_reg;
    logic                 granted_reg;
    logic [AVAIL_W-1:0]   avail_reg;

    logic                 m_valid_reg;
    logic                 m_granted_reg;
    logic [AVAIL_W-1:0]   m_available_reg;

    logic [RID_EXT_W-1:0] rid_ext;
    logic [CAP_W-1:0]     cap_wide;
    logic [LEVEL_W-1:0]   cap;
    logic [MEM_W-1:0]     rdata;
    logic [LEVEL_W-1:0]   rd_level;
    logic [TIME_BITS-1:0] rd_time;
    logic                 entry_ok;
    logic                 need_mul;
    logic                 out_load;
    logic                 mem_we;
    logic                 take_ok;
    logic [LEVEL_W-1:0]   take_lvl;
    logic [LEVEL_W-1:0]   take_whole;
    mul_stat_t            mul_stat;

    assign rid_ext  = {{(RID_EXT_W - RID_W){1'b0}}, s_resource_id};

    // capacity = burst << FRAC_BITS, saturated to the level width
    assign cap_wide = CAP_W'(burst_reg) << FRAC_BITS;
    assign cap      = (|cap_wide[CAP_W-1:LEVEL_W]) ? '1 : cap_wide[LEVEL_W-1:0];

    assign rd_level = rdata[LEVEL_W-1:0];
    assign rd_time  = rdata[MEM_W-1:LEVEL_W];
    assign entry_ok = in_range_reg && valid_reg[idx_reg];

    assign need_mul = (state_reg == ST_EVAL) && in_range_reg && entry_ok
                   && (op_reg == OP_ACQUIRE || op_reg == OP_QUERY)
                   && (rd_level < cap);

    // take one token on acquire if the level holds one, then whole tokens saturated to 16 bits
    assign take_ok    = (op_reg == OP_ACQUIRE) && (lvl_reg >= ONE_TOKEN);
    assign take_lvl   = take_ok ? (lvl_reg - ONE_TOKEN) : lvl_reg;
    assign take_whole = take_lvl >> FRAC_BITS;

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign mem_we   = out_load && wr_reg;

    ptb_mem #(
        .DEPTH (NUM_RESOURCES),
        .AW    (IDX_W),
        .DW    (MEM_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata ({now_reg, lvl_reg}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    ptb_mul #(
        .TIME_BITS (TIME_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (need_mul),
        .elapsed (now_reg - rd_time),
        .rate    (rate_reg),
        .stat    (mul_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rate_reg    <= LEVEL_W'(65536);
            burst_reg   <= BURST_W'(16);
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_RATE:  rate_reg  <= cfg_wdata[LEVEL_W-1:0];
                    CFG_BURST: burst_reg <= cfg_wdata[BURST_W-1:0];
                    default: ;
                endcase
            end

            // drained and not reloaded in the same cycle
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg       <= op_t'(s_op);
                        idx_reg      <= rid_ext[IDX_W-1:0];
                        in_range_reg <= rid_ext < RID_EXT_W'(NUM_RESOURCES);
                        now_reg      <= TIME_BITS'(s_now_time);
                        state_reg    <= ST_RD;
                    end
                end
                ST_RD: begin
                    // read data lands at this edge
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    granted_reg <= 1'b0;
                    wr_reg      <= (op_reg == OP_RESET_ONE) && entry_ok;
                    // unknown bucket on query reports the burst size
                    avail_reg   <= (op_reg == OP_QUERY && in_range_reg && !entry_ok) ?
                                   burst_reg : '0;
                    if (op_reg == OP_RESET_ALL) begin
                        valid_reg <= '0;
                        state_reg <= ST_DONE;
                    end else if (!in_range_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        unique case (op_reg) inside
                            OP_ACQUIRE, OP_QUERY: begin
                                if (!entry_ok) begin
                                    if (op_reg == OP_ACQUIRE) begin
                                        // new bucket starts full
                                        valid_reg[idx_reg] <= 1'b1;
                                        lvl_reg   <= cap;
                                        state_reg <= ST_TAKE;
                                    end else begin
                                        state_reg <= ST_DONE;
                                    end
                                end else if (rd_level >= cap) begin
                                    lvl_reg   <= cap;
                                    state_reg <= ST_TAKE;
                                end else begin
                                    lvl_reg   <= rd_level;
                                    room_reg  <= cap - rd_level;
                                    state_reg <= ST_MUL;
                                end
                            end
                            OP_RESET_ONE: begin
                                lvl_reg   <= cap;
                                state_reg <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_MUL: begin
                    if (mul_stat.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // refill saturates at capacity when the product overshoots
                    if (mul_stat.sat || (mul_stat.product > room_reg)) begin
                        lvl_reg <= cap;
                    end else begin
                        lvl_reg <= lvl_reg + mul_stat.product;
                    end
                    state_reg <= ST_TAKE;
                end
                ST_TAKE: begin
                    lvl_reg     <= take_lvl;
                    granted_reg <= take_ok;
                    avail_reg   <= (|take_whole[LEVEL_W-1:AVAIL_W]) ?
                                   '1 : take_whole[AVAIL_W-1:0];
                    wr_reg      <= 1'b1;
                    state_reg   <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        m_valid_reg     <= 1'b1;
                        m_granted_reg   <= granted_reg;
                        m_available_reg <= avail_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_granted   = m_granted_reg;
    assign m_available = m_available_reg;

    // a result only appears out of the final step
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result register loaded outside final step");

    // multiplier finishes only while the sequencer waits for it
    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> state_reg == ST_MUL)
        else $error("multiplier done outside multiply step");

    // only an acquire can grant
    a_grant_acquire: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && granted_reg) |-> op_reg == OP_ACQUIRE)
        else $error("grant on a non-acquire item");

    // memory is written only by in-range items
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> in_range_reg && op_reg != OP_RESET_ALL)
        else $error("bucket write for an item that addresses none");

endmodule
